/* rtl/dlrs_pkg.sv */
`default_nettype none
package dlrs_pkg;
    localparam int unsigned DEPTH = 64;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned KEY_W = 31;
    localparam int unsigned ENTRY_W = 2 * KEY_W;
    localparam int unsigned RADIX = 10;
    localparam int unsigned DIG_W = 4;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [DIG_W-1:0] digit_t;

    // Store entry: the key and the key divided by the current digit weight.
    typedef struct packed {
        key_t key;
        key_t rest;
    } entry_t;

    // Split a key below 2^31 into its quotient by ten and the remainder.
    typedef struct packed {
        key_t   quot;
        digit_t rem;
    } divmod_t;

    function automatic divmod_t div10(input key_t value);
        logic [63:0] prod;
        logic [KEY_W-1:0] q;
        logic [KEY_W+3:0] back;
        logic [KEY_W+3:0] r;
        divmod_t res;
        prod = {33'd0, value} * 64'd3435973837;
        q = KEY_W'(prod >> 35);
        back = {4'd0, q} * 35'd10;
        r = {4'd0, value} - back;
        res.quot = q;
        res.rem = r[DIG_W-1:0];
        return res;
    endfunction
endpackage
`default_nettype wire

/* rtl/dlrs_ram.sv */
`default_nettype none
module dlrs_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]               wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/decimal_lsd_radix_sorter_unit.sv */
`default_nettype none
// Decimal LSD radix sorter. Keys stream in on s_axis at one per cycle, up to
// DEPTH (64); extra keys are dropped and flag overflow on every result of the
// set. The key with tlast closes the set, after which the block sorts ascending
// by decimal digits and streams the keys out on m_axis, tlast on the last one.
// Each store entry holds the key and its quotient by the current digit weight,
// so a digit comes from one divide-by-ten of the entry just read. Each digit
// pass reads the store twice through one single-port-read RAM (histogram sweep,
// then backward scatter into a second RAM) with nine prefix-sum steps between,
// then a copy sweep back and a setup state; one pass per decimal digit of the
// largest key (0 to 10 passes). The keys then stream out with one read in flight
// at a time, the next key being read only when the current one is taken. No new
// key is taken until the result stream ends.
module decimal_lsd_radix_sorter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [30:0] key_value, [31] zero
    input  wire logic        s_axis_tlast,  // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // [30:0] sorted_key, [31] zero
    output logic             m_axis_tlast,  // end_of_run
    output logic             m_axis_tuser   // overflow
);
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_HIST = 3'd1;
    localparam logic [2:0] ST_PSUM = 3'd2;
    localparam logic [2:0] ST_SCAT = 3'd3;
    localparam logic [2:0] ST_COPY = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_NEXT = 3'd6;

    localparam int unsigned AW = dlrs_pkg::ADDR_W;
    localparam int unsigned CW = dlrs_pkg::CNT_W;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    dlrs_pkg::key_t max_reg, max_next;
    logic drop_reg, drop_next;
    logic [CW-1:0] cnt_reg [dlrs_pkg::RADIX];
    logic [CW-1:0] cnt_next [dlrs_pkg::RADIX];
    logic [CW:0] idx_reg, idx_next;          // walk index, one extra for latency
    dlrs_pkg::key_t rest_reg, rest_next;     // max divided by the digit weight
    logic [dlrs_pkg::DIG_W-1:0] pidx_reg, pidx_next;
    logic ovalid_reg, ovalid_next;
    dlrs_pkg::key_t okey_reg, okey_next;
    logic olast_reg, olast_next;
    logic rd_ok_reg, rd_ok_next;             // RAM read issued last cycle

    logic key_we, scr_we;
    logic [AW-1:0] key_waddr, key_raddr, scr_waddr, scr_raddr;
    dlrs_pkg::entry_t key_wdata, key_rdata, scr_wdata, scr_rdata;

    dlrs_ram #(.WIDTH(dlrs_pkg::ENTRY_W), .DEPTH(dlrs_pkg::DEPTH)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );
    dlrs_ram #(.WIDTH(dlrs_pkg::ENTRY_W), .DEPTH(dlrs_pkg::DEPTH)) u_scr_ram (
        .aclk(aclk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
        .raddr(scr_raddr), .rdata(scr_rdata)
    );

    // Digit of the entry being read; the scattered entry advances to the next weight.
    dlrs_pkg::divmod_t rd_div;
    dlrs_pkg::digit_t rd_digit;
    always_comb begin
        rd_div = dlrs_pkg::div10(key_rdata.rest);
        rd_digit = rd_div.rem;
        scr_wdata = {key_rdata.key, rd_div.quot};
    end

    logic s_fire, m_fire;
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {1'b0, okey_reg};
    assign m_axis_tlast = olast_reg;
    assign m_axis_tuser = drop_reg;

    logic [CW-1:0] pos;
    always_comb begin
        state_next = state_reg;
        n_next = n_reg;
        max_next = max_reg;
        drop_next = drop_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        rest_next = rest_reg;
        pidx_next = pidx_reg;
        ovalid_next = ovalid_reg;
        okey_next = okey_reg;
        olast_next = olast_reg;
        rd_ok_next = 1'b0;
        key_we = 1'b0;
        key_waddr = n_reg[AW-1:0];
        key_wdata = {s_axis_tdata[dlrs_pkg::KEY_W-1:0], s_axis_tdata[dlrs_pkg::KEY_W-1:0]};
        key_raddr = '0;
        scr_we = 1'b0;
        scr_waddr = '0;
        scr_raddr = '0;
        pos = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (n_reg < CW'(dlrs_pkg::DEPTH)) begin
                        key_we = 1'b1;
                        n_next = n_reg + 1'b1;
                        if (s_axis_tdata[dlrs_pkg::KEY_W-1:0] > max_reg) begin
                            max_next = s_axis_tdata[dlrs_pkg::KEY_W-1:0];
                        end
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        rest_next = (s_axis_tdata[dlrs_pkg::KEY_W-1:0] > max_reg &&
                                     n_reg < CW'(dlrs_pkg::DEPTH)) ?
                                    s_axis_tdata[dlrs_pkg::KEY_W-1:0] : max_reg;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                // Start a pass while max / weight is nonzero, else stream out.
                for (int d = 0; d < dlrs_pkg::RADIX; d++) cnt_next[d] = '0;
                idx_next = '0;
                if (rest_reg != '0) begin
                    state_next = ST_HIST;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_HIST: begin
                key_raddr = idx_reg[AW-1:0];
                if (idx_reg < {1'b0, n_reg}) begin
                    rd_ok_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_ok_reg) begin
                    cnt_next[rd_digit] = cnt_reg[rd_digit] + 1'b1;
                end
                if (!rd_ok_reg && idx_reg == {1'b0, n_reg}) begin
                    pidx_next = 4'd1;
                    state_next = ST_PSUM;
                end
            end
            ST_PSUM: begin
                cnt_next[pidx_reg] = cnt_reg[pidx_reg] + cnt_reg[pidx_reg - 1'b1];
                if (pidx_reg == dlrs_pkg::DIG_W'(dlrs_pkg::RADIX - 1)) begin
                    idx_next = {1'b0, n_reg};
                    state_next = ST_SCAT;
                end else begin
                    pidx_next = pidx_reg + 1'b1;
                end
            end
            ST_SCAT: begin
                // Walk backward; the digit count for the read key gives its slot.
                key_raddr = AW'(idx_reg - 1'b1);
                if (idx_reg != '0) begin
                    rd_ok_next = 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
                if (rd_ok_reg) begin
                    pos = cnt_reg[rd_digit] - 1'b1;
                    cnt_next[rd_digit] = pos;
                    scr_we = 1'b1;
                    scr_waddr = pos[AW-1:0];
                end
                if (!rd_ok_reg && idx_reg == '0) begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY: begin
                scr_raddr = idx_reg[AW-1:0];
                if (idx_reg < {1'b0, n_reg}) begin
                    rd_ok_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_ok_reg) begin
                    key_we = 1'b1;
                    key_waddr = AW'(idx_reg - 1'b1);
                    key_wdata = scr_rdata;
                end
                if (!rd_ok_reg && idx_reg == {1'b0, n_reg}) begin
                    rest_next = dlrs_pkg::div10(rest_reg).quot;
                    state_next = ST_NEXT;
                end
            end
            ST_OUT: begin
                // One read in flight at a time; hold while the output waits.
                key_raddr = idx_reg[AW-1:0];
                if (m_fire) begin
                    ovalid_next = 1'b0;
                    if (olast_reg) begin
                        n_next = '0;
                        max_next = '0;
                        drop_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
                if (rd_ok_reg) begin
                    ovalid_next = 1'b1;
                    okey_next = key_rdata.key;
                    olast_next = (idx_reg == {1'b0, n_reg});
                end else if ((!ovalid_reg || m_fire) && !olast_reg &&
                             idx_reg < {1'b0, n_reg}) begin
                    rd_ok_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (m_fire && olast_reg) begin
                    olast_next = 1'b0;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            n_reg <= '0;
            max_reg <= '0;
            drop_reg <= 1'b0;
            for (int d = 0; d < dlrs_pkg::RADIX; d++) cnt_reg[d] <= '0;
            idx_reg <= '0;
            rest_reg <= '0;
            pidx_reg <= '0;
            ovalid_reg <= 1'b0;
            olast_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg <= n_next;
            max_reg <= max_next;
            drop_reg <= drop_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            rest_reg <= rest_next;
            pidx_reg <= pidx_next;
            ovalid_reg <= ovalid_next;
            olast_reg <= olast_next;
            rd_ok_reg <= rd_ok_next;
        end
        okey_reg <= okey_next;
    end
endmodule
`default_nettype wire
